// ----- rtl/core/ethernet_fragment_fcs_checker_unit_defines.svh -----
// Assertion macros for the fragment FCS checker.
`ifndef ETHERNET_FRAGMENT_FCS_CHECKER_UNIT_DEFINES_SVH
`define ETHERNET_FRAGMENT_FCS_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EFFCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define EFFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/effcc_pkg.sv -----
package effcc_pkg;

    localparam logic [31:0] MCRC_XOR_MASK   = 32'hFFFF_0000;
    localparam logic [31:0] CRC_POLY_REFL   = 32'hEDB8_8320;
    localparam int          CMD_DEPTH_DFLT  = 2;
    localparam int          RES_DEPTH_DFLT  = 2;

    typedef enum logic [1:0] {
        OP_EXTEND,
        OP_START_FIRST,
        OP_START_RESUME
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        check;
        logic [7:0]  data_byte;
        logic [31:0] received_fcs;
    } cmd_t;

    typedef struct packed {
        logic fcs_ok;
        logic last_fragment;
    } res_t;

    // Extend a published-form (pre/post inverted) CRC-32 by one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = ~crc ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

// ----- rtl/core/effcc_front.sv -----
module effcc_front
    import effcc_pkg::*;
(
    input  logic        push,
    input  logic [7:0]  data_byte,
    input  logic        start_of_packet,
    input  logic        first_fragment,
    input  logic        end_of_data,
    input  logic [31:0] received_fcs,
    output logic        cmd_push,
    output cmd_t        cmd
);

    op_t op;

    always_comb
    begin
        unique case ({start_of_packet, first_fragment}) inside
            2'b11:        op = OP_START_FIRST;
            2'b10:        op = OP_START_RESUME;
            2'b00, 2'b01: op = OP_EXTEND;
            default:      op = OP_EXTEND;
        endcase
    end

    assign cmd_push         = push;
    assign cmd.op           = op;
    assign cmd.check        = end_of_data;
    assign cmd.data_byte    = data_byte;
    assign cmd.received_fcs = received_fcs;

endmodule

// ----- rtl/core/effcc_fifo.sv -----
module effcc_fifo
    import effcc_pkg::*;
#(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/effcc_back.sv -----
module effcc_back
    import effcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_empty,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    logic [31:0] frag_crc_reg, frag_crc_next;
    logic [31:0] run_crc_reg, run_crc_next;
    logic [31:0] saved_crc_reg, saved_crc_next;
    logic [31:0] frag_base, run_base;
    logic        is_last, ok;

    // a checking byte needs room for its result; plain bytes never wait
    assign cmd_pop  = !cmd_empty && (!cmd.check || !res_full);
    assign res_push = cmd_pop && cmd.check;

    always_comb
    begin
        unique case (cmd.op)
            OP_START_FIRST:
            begin
                frag_base = '0;
                run_base  = '0;
            end
            OP_START_RESUME:
            begin
                frag_base = '0;
                run_base  = saved_crc_reg;
            end
            OP_EXTEND:
            begin
                frag_base = frag_crc_reg;
                run_base  = run_crc_reg;
            end
            default:
            begin
                frag_base = frag_crc_reg;
                run_base  = run_crc_reg;
            end
        endcase

        frag_crc_next = crc32_byte(frag_base, cmd.data_byte);
        run_crc_next  = crc32_byte(run_base, cmd.data_byte);

        // fcs equal to the mCRC marks an intermediate fragment
        is_last = (cmd.received_fcs != (frag_crc_next ^ MCRC_XOR_MASK));
        ok      = !is_last || (cmd.received_fcs == run_crc_next);

        saved_crc_next = (res_push && ok) ? run_crc_next : saved_crc_reg;

        res.fcs_ok        = ok;
        res.last_fragment = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_crc_reg  <= '0;
            run_crc_reg   <= '0;
            saved_crc_reg <= '0;
        end
        else if (cmd_pop)
        begin
            frag_crc_reg  <= frag_crc_next;
            run_crc_reg   <= run_crc_next;
            saved_crc_reg <= saved_crc_next;
        end
    end

endmodule

// ----- rtl/core/ethernet_fragment_fcs_checker_unit.sv -----
// A request accepted into the command queue is popped by the back end, which writes its
//   result into the result queue (empty falls after that write) when the queue has room.
// Throughput: one byte per cycle into both CRCs; an end_of_data byte waits for result room.
// Only bytes flagged end_of_data produce a result.
// Reset (rst_n low, asynchronous): queues empty, all three CRC registers cleared to zero.
`include "ethernet_fragment_fcs_checker_unit_defines.svh"

module ethernet_fragment_fcs_checker_unit
    import effcc_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DFLT,
    parameter int RES_DEPTH = RES_DEPTH_DFLT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        start_of_packet,
    input  logic        first_fragment,
    input  logic        end_of_data,
    input  logic [31:0] received_fcs,
    output logic        empty,
    input  logic        pop,
    output logic        fcs_ok,
    output logic        last_fragment
);

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    cmd_t             cmd_wr, cmd_rd;
    logic [CMD_W-1:0] cmd_rd_vec;
    logic             cmd_push, cmd_pop, cmd_empty;
    res_t             res_wr, res_rd;
    logic [RES_W-1:0] res_rd_vec;
    logic             res_push, res_full;

    effcc_front u_front (
        .push            (push),
        .data_byte       (data_byte),
        .start_of_packet (start_of_packet),
        .first_fragment  (first_fragment),
        .end_of_data     (end_of_data),
        .received_fcs    (received_fcs),
        .cmd_push        (cmd_push),
        .cmd             (cmd_wr)
    );

    effcc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_wr),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd_vec),
        .empty   (cmd_empty)
    );

    assign cmd_rd = cmd_t'(cmd_rd_vec);

    effcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_rd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_wr)
    );

    effcc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_vec),
        .empty   (empty)
    );

    assign res_rd        = res_t'(res_rd_vec);
    assign fcs_ok        = res_rd.fcs_ok;
    assign last_fragment = res_rd.last_fragment;

    `EFFCC_ASSERT_NOW(a_res_room, res_push, !res_full, "result written into a full queue")
    `EFFCC_ASSERT_NOW(a_cmd_avail, cmd_pop, !cmd_empty, "command taken from an empty queue")
    `EFFCC_ASSERT_NEXT(a_res_shows, cmd_pop && cmd_rd.check, !empty, "checked byte left no result")

endmodule
